>>> hdl/isotp_rx_pkg.sv
// Shared types and codes for the ISO-TP receive reassembler.
`default_nettype none

package isotp_rx_pkg;

  localparam int LEN_W  = 12;
  localparam int DATA_W = 64;
  localparam int ID_W   = 29;
  localparam int CFG_W  = 29;

  localparam logic [3:0] PCI_SINGLE      = 4'h0;
  localparam logic [3:0] PCI_FIRST       = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;
  localparam logic [3:0] NIBBLE_MASK     = 4'hF;

  localparam logic [1:0] FS_CONTINUE = 2'd0;
  localparam logic [1:0] FS_OVERFLOW = 2'd2;

  localparam logic [6:0] ST_MIN_MAX = 7'h7F;

  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_LENGTH   = 3'd1,
    STS_OVERFLOW = 3'd2,
    STS_WRONG_SN = 3'd3,
    STS_NO_DATA  = 3'd4,
    STS_IGNORED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_BUSY = 2'd1,
    RX_FULL = 2'd2
  } rx_state_e;

  typedef enum logic [2:0] {
    LR_OK       = 3'd0,
    LR_UNEXP    = 3'd1,
    LR_WRONG_SN = 3'd2,
    LR_OVFLW    = 3'd3,
    LR_TIMEOUT  = 3'd4
  } link_e;

  typedef enum logic [1:0] {
    CFG_BS_FRAMES     = 2'd0,
    CFG_ST_MIN        = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2,
    CFG_TX_ID         = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]      bs_frames;
    logic [7:0]      st_min_raw;
    logic [15:0]     timeout_ticks;
    logic [ID_W-1:0] tx_id;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [3:0]       frame_length;
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    status_e          status;
    rx_state_e        rx_state;
    link_e            link_result;
    logic             fc_send;
    logic [1:0]       fc_flow_status;
    logic [7:0]       fc_block_size;
    logic [6:0]       fc_st_min;
    logic [ID_W-1:0]  fc_can_id;
    logic [LEN_W-1:0] message_length;
    logic [7:0]       read_byte;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage : isotp_rx_pkg

`default_nettype wire

>>> hdl/isotp_receive_reassembler_unit.sv
// Top level of the ISO-TP receive reassembler: configuration, sequencer, store, output register.
`default_nettype none

// Takes one request at a time: a CAN frame, a timeout tick, a byte read or a message
// release, and returns exactly one result per request. A request passes an execute state,
// then where needed a copy state that writes its payload bytes to the byte-wide single-port
// message store one at a time (up to 7 for a single or consecutive frame, 6 for a first
// frame) or a read state for a byte read, then a done state that holds the result until
// the output register takes it. A finished result sits in the output register while the
// next request is accepted. Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i;
// the user must write it only while idle, as the block itself does not enforce this.
module isotp_receive_reassembler_unit #(
  parameter int BUFFER_BYTES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [28:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_length[3:0], frame_data[67:4], read_index[79:68]
  input  wire  [79:0] s_axis_tdata,
  // op[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[2:0], rx_state[4:3], link_result[7:5], fc_send[8], fc_flow_status[10:9],
  // fc_block_size[18:11], fc_st_min[25:19], fc_can_id[54:26], message_length[66:55],
  // read_byte[74:67], zero[79:75]
  output logic [79:0] m_axis_tdata
);
  import isotp_rx_pkg::*;

  cfg_t     cfg_q;
  item_t    item;
  result_t  res;
  logic     res_valid;
  logic     res_ready;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;
  logic     out_valid_q;
  result_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bs_frames     <= 8'd8;
      cfg_q.st_min_raw    <= 8'd0;
      cfg_q.timeout_ticks <= 16'd100;
      cfg_q.tx_id         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BS_FRAMES:     cfg_q.bs_frames     <= cfg_data_i[7:0];
        CFG_ST_MIN:        cfg_q.st_min_raw    <= cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[15:0];
        CFG_TX_ID:         cfg_q.tx_id         <= cfg_data_i[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.op           = op_e'(s_axis_tuser);
    item.frame_length = s_axis_tdata[3:0];
    item.frame_data   = s_axis_tdata[67:4];
    item.read_index   = s_axis_tdata[79:68];
  end

  isotp_rx_seq #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  isotp_rx_store #(
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.read_byte, out_q.message_length, out_q.fc_can_id,
                          out_q.fc_st_min, out_q.fc_block_size, out_q.fc_flow_status,
                          out_q.fc_send, out_q.link_result, out_q.rx_state,
                          out_q.status};

endmodule : isotp_receive_reassembler_unit

`default_nettype wire

>>> hdl/isotp_rx_store.sv
// Byte-wide single-port message store with registered read data.
`default_nettype none

module isotp_rx_store #(
  parameter int DEPTH = 4096
) (
  input  wire                      clk_i,
  input  wire isotp_rx_pkg::mem_req_t req_i,
  output logic [7:0]               rdata_o
);
  import isotp_rx_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [ADDR_W-1:0] addr;

  assign addr = req_i.addr[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr] <= req_i.wdata;
    end
    rdata_o <= mem[addr];
  end

endmodule : isotp_rx_store

`default_nettype wire

>>> hdl/isotp_rx_seq.sv
// Frame decoder and byte-copy sequencer that owns the reassembly state.
`default_nettype none

module isotp_rx_seq #(
  parameter int BUFFER_BYTES = 4096
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire isotp_rx_pkg::cfg_t  cfg_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire isotp_rx_pkg::item_t in_item_i,
  output logic                     res_valid_o,
  input  wire                      res_ready_i,
  output isotp_rx_pkg::result_t    res_o,
  output isotp_rx_pkg::mem_req_t   mem_req_o,
  input  wire [7:0]                mem_rdata_i
);
  import isotp_rx_pkg::*;

  localparam logic [LEN_W:0] BUF_LIMIT = (LEN_W+1)'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_COPY,
    SQ_READ,
    SQ_DONE
  } seq_e;

  seq_e              state_q;
  item_t             item_q;
  logic [DATA_W-1:0] data_q;
  logic [2:0]        copy_cnt_q;
  logic [LEN_W-1:0]  addr_q;
  result_t           res_q;

  rx_state_e        rx_q, rx_d;
  link_e            link_q, link_d;
  logic [3:0]       exp_seq_q, exp_seq_d;
  logic [LEN_W-1:0] total_q, total_d;
  logic [LEN_W-1:0] wr_off_q, wr_off_d;
  logic [7:0]       frames_left_q, frames_left_d;
  logic [15:0]      timeout_q, timeout_d;

  // Decisions taken in the execute cycle.
  status_e          status_d;
  logic             fc_d;
  logic [1:0]       fc_flow_d;
  logic [7:0]       fc_bs_d;
  logic [6:0]       fc_st_d;
  logic [2:0]       copy_n_d;
  logic [LEN_W-1:0] copy_base_d;
  logic             copy_skip2_d;
  logic             do_read_d;

  always_comb begin
    logic [3:0]       pci_type;
    logic [3:0]       pci_low;
    logic [3:0]       len_m1;
    logic [LEN_W-1:0] ff_len;
    logic [LEN_W-1:0] remain;
    logic [2:0]       cf_n;
    logic [LEN_W-1:0] off_next;
    logic [7:0]       fl_dec;

    pci_type = item_q.frame_data[63:60];
    pci_low  = item_q.frame_data[59:56] & NIBBLE_MASK;
    len_m1   = item_q.frame_length - 4'd1;
    ff_len   = {pci_low, item_q.frame_data[55:48]};
    remain   = (total_q > wr_off_q) ? (total_q - wr_off_q) : '0;
    cf_n     = (remain > LEN_W'(7)) ? 3'd7 : remain[2:0];
    off_next = wr_off_q + LEN_W'(cf_n);
    fl_dec   = frames_left_q - 8'd1;

    rx_d          = rx_q;
    link_d        = link_q;
    exp_seq_d     = exp_seq_q;
    total_d       = total_q;
    wr_off_d      = wr_off_q;
    frames_left_d = frames_left_q;
    timeout_d     = timeout_q;
    status_d      = STS_OK;
    fc_d          = 1'b0;
    fc_flow_d     = FS_CONTINUE;
    fc_bs_d       = '0;
    fc_st_d       = '0;
    copy_n_d      = '0;
    copy_base_d   = '0;
    copy_skip2_d  = 1'b0;
    do_read_d     = 1'b0;

    case (item_q.op)
      OP_FRAME: begin
        if (item_q.frame_length < 4'd2 || item_q.frame_length > 4'd8) begin
          status_d = STS_IGNORED;
        end else begin
          if (pci_type == PCI_SINGLE || pci_type == PCI_FIRST) begin
            link_d = (rx_q == RX_BUSY) ? LR_UNEXP : LR_OK;
          end
          if (pci_type == PCI_SINGLE) begin
            if (pci_low == 4'd0 || pci_low > len_m1) begin
              status_d = STS_LENGTH;
            end else begin
              copy_n_d = pci_low[2:0];
              total_d  = LEN_W'(pci_low);
              rx_d     = RX_FULL;
            end
          end else if (pci_type == PCI_FIRST) begin
            if (item_q.frame_length != 4'd8 || ff_len <= LEN_W'(7)) begin
              status_d = STS_LENGTH;
            end else if ({1'b0, ff_len} > BUF_LIMIT) begin
              link_d    = LR_OVFLW;
              rx_d      = RX_IDLE;
              fc_d      = 1'b1;
              fc_flow_d = FS_OVERFLOW;
              status_d  = STS_OVERFLOW;
            end else begin
              copy_n_d      = 3'd6;
              copy_skip2_d  = 1'b1;
              total_d       = ff_len;
              wr_off_d      = LEN_W'(6);
              exp_seq_d     = 4'd1;
              rx_d          = RX_BUSY;
              frames_left_d = cfg_i.bs_frames;
              fc_d          = 1'b1;
              fc_bs_d       = cfg_i.bs_frames;
              fc_st_d       = (cfg_i.st_min_raw > 8'(ST_MIN_MAX)) ? ST_MIN_MAX
                                                                  : cfg_i.st_min_raw[6:0];
              timeout_d     = cfg_i.timeout_ticks;
            end
          end else if (pci_type == PCI_CONSECUTIVE) begin
            if (rx_q != RX_BUSY) begin
              link_d   = LR_UNEXP;
              status_d = STS_IGNORED;
            end else if (pci_low != exp_seq_q) begin
              link_d   = LR_WRONG_SN;
              rx_d     = RX_IDLE;
              status_d = STS_WRONG_SN;
            end else if ({1'b0, cf_n} > len_m1) begin
              status_d = STS_LENGTH;
            end else begin
              copy_n_d    = cf_n;
              copy_base_d = wr_off_q;
              wr_off_d    = off_next;
              exp_seq_d   = exp_seq_q + 4'd1;
              timeout_d   = cfg_i.timeout_ticks;
              if (off_next >= total_q) begin
                rx_d = RX_FULL;
              end else if (frames_left_q != 8'd0) begin
                frames_left_d = fl_dec;
                if (fl_dec == 8'd0) begin
                  frames_left_d = cfg_i.bs_frames;
                  fc_d          = 1'b1;
                  fc_bs_d       = cfg_i.bs_frames;
                  fc_st_d       = (cfg_i.st_min_raw > 8'(ST_MIN_MAX)) ? ST_MIN_MAX
                                                                      : cfg_i.st_min_raw[6:0];
                end
              end
            end
          end else begin
            status_d = STS_IGNORED;
          end
        end
      end
      OP_TICK: begin
        if (rx_q == RX_BUSY) begin
          if (timeout_q == 16'd0) begin
            link_d = LR_TIMEOUT;
            rx_d   = RX_IDLE;
          end else begin
            timeout_d = timeout_q - 16'd1;
          end
        end
      end
      OP_READ: begin
        if (rx_q != RX_FULL) begin
          status_d = STS_NO_DATA;
        end else if (item_q.read_index >= total_q ||
                     {1'b0, item_q.read_index} >= BUF_LIMIT) begin
          status_d = STS_LENGTH;
        end else begin
          do_read_d = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (rx_q != RX_FULL) begin
          status_d = STS_NO_DATA;
        end else begin
          rx_d = RX_IDLE;
        end
      end
      default: begin
        status_d = STS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SQ_IDLE;
      rx_q          <= RX_IDLE;
      link_q        <= LR_OK;
      exp_seq_q     <= '0;
      total_q       <= '0;
      wr_off_q      <= '0;
      frames_left_q <= '0;
      timeout_q     <= '0;
      copy_cnt_q    <= '0;
    end else begin
      case (state_q)
        SQ_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            data_q  <= in_item_i.frame_data;
            state_q <= SQ_EXEC;
          end
        end
        SQ_EXEC: begin
          rx_q          <= rx_d;
          link_q        <= link_d;
          exp_seq_q     <= exp_seq_d;
          total_q       <= total_d;
          wr_off_q      <= wr_off_d;
          frames_left_q <= frames_left_d;
          timeout_q     <= timeout_d;
          copy_cnt_q    <= copy_n_d;
          addr_q        <= copy_base_d;
          // Line the first payload byte up at the top of the shifter.
          data_q        <= copy_skip2_d ? (data_q << 16) : (data_q << 8);
          res_q.status         <= status_d;
          res_q.rx_state       <= rx_d;
          res_q.link_result    <= link_d;
          res_q.fc_send        <= fc_d;
          res_q.fc_flow_status <= fc_flow_d;
          res_q.fc_block_size  <= fc_bs_d;
          res_q.fc_st_min      <= fc_st_d;
          res_q.fc_can_id      <= fc_d ? cfg_i.tx_id : '0;
          res_q.message_length <= total_d;
          res_q.read_byte      <= '0;
          if (copy_n_d != 3'd0) begin
            state_q <= SQ_COPY;
          end else if (do_read_d) begin
            state_q <= SQ_READ;
          end else begin
            state_q <= SQ_DONE;
          end
        end
        SQ_COPY: begin
          copy_cnt_q <= copy_cnt_q - 3'd1;
          addr_q     <= addr_q + LEN_W'(1);
          data_q     <= data_q << 8;
          if (copy_cnt_q == 3'd1) begin
            state_q <= SQ_DONE;
          end
        end
        SQ_READ: begin
          res_q.read_byte <= mem_rdata_i;
          state_q         <= SQ_DONE;
        end
        SQ_DONE: begin
          if (res_ready_i) begin
            state_q <= SQ_IDLE;
          end
        end
        default: begin
          state_q <= SQ_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == SQ_IDLE);
  assign res_valid_o = (state_q == SQ_DONE);
  assign res_o       = res_q;

  always_comb begin
    mem_req_o.we    = (state_q == SQ_COPY);
    mem_req_o.addr  = (state_q == SQ_COPY) ? addr_q : item_q.read_index;
    mem_req_o.wdata = data_q[DATA_W-1 -: 8];
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == SQ_EXEC)
    else $error("accepted item did not enter execute");

  a_busy_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_q == RX_BUSY |-> wr_off_q < total_q)
    else $error("message in progress with write offset at or past its length");

  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SQ_COPY |-> copy_cnt_q != 3'd0)
    else $error("byte copy running with nothing left to copy");

  a_no_write_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !mem_req_o.we)
    else $error("store written while a result is offered");

endmodule : isotp_rx_seq

`default_nettype wire

>>> tb/sv/isotp_receive_reassembler_unit_tb.sv
// Self-checking testbench for the ISO-TP receive reassembler with a built-in reassembly predictor.
`timescale 1ns / 100ps

module isotp_receive_reassembler_unit_tb;
  import isotp_rx_pkg::*;

  localparam int unsigned BUF_BYTES = 4096;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [28:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // frame_length[3:0], frame_data[67:4], read_index[79:68]
  logic [79:0] s_axis_tdata = '0;
  // op[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[2:0], rx_state[4:3], link_result[7:5], fc_send[8], fc_flow_status[10:9],
  // fc_block_size[18:11], fc_st_min[25:19], fc_can_id[54:26], message_length[66:55],
  // read_byte[74:67], zero[79:75]
  logic [79:0] m_axis_tdata;

  isotp_receive_reassembler_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: a private copy of the receiver and its registers.
  cfg_t        cfg;
  rx_state_e   rx_st;
  link_e       link_res;
  logic [3:0]  exp_sn;
  logic [11:0] total_len;
  logic [11:0] wr_off;
  logic [7:0]  blk_left;
  logic [15:0] tmo_left;
  logic [7:0]  msg_mem [BUF_BYTES];

  item_t       req_q[$];
  result_t     reply_q[$];
  item_t       cur_req;
  int unsigned counted = 0;
  int unsigned err_count = 0;
  int unsigned reply_no = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned src_wait;
  int unsigned sink_wait;
  bit          no_stall = 1'b0;

  function automatic result_t with_fc(result_t r, logic [1:0] flow, logic [7:0] bs,
                                      logic [7:0] st);
    r.fc_send        = 1'b1;
    r.fc_flow_status = flow;
    r.fc_block_size  = bs;
    r.fc_st_min      = (st > 8'(ST_MIN_MAX)) ? ST_MIN_MAX : st[6:0];
    r.fc_can_id      = cfg.tx_id;
    return r;
  endfunction

  // Works out the one reply that a request causes and advances the predictor state.
  function automatic result_t reassemble(item_t it);
    result_t     r;
    logic [7:0]  b [8];
    logic [3:0]  kind;
    int unsigned n;
    int unsigned len;
    r = '0;
    r.status = STS_OK;
    len = it.frame_length;
    case (it.op)
      OP_FRAME: begin
        if (len < 2 || len > 8) begin
          r.status = STS_IGNORED;
        end else begin
          for (int i = 0; i < 8; i++) b[i] = (i < len) ? it.frame_data[63 - 8 * i -: 8] : 8'h00;
          kind = b[0][7:4];
          if (kind == PCI_SINGLE || kind == PCI_FIRST) begin
            link_res = (rx_st == RX_BUSY) ? LR_UNEXP : LR_OK;
          end
          if (kind == PCI_SINGLE) begin
            n = b[0][3:0];
            if (n == 0 || n > len - 1) begin
              r.status = STS_LENGTH;
            end else begin
              for (int i = 0; i < n; i++) msg_mem[i] = b[1 + i];
              total_len = 12'(n);
              rx_st = RX_FULL;
            end
          end else if (kind == PCI_FIRST) begin
            n = {b[0][3:0], b[1]};
            if (len != 8 || n <= 7) begin
              r.status = STS_LENGTH;
            end else if (n > BUF_BYTES) begin
              link_res = LR_OVFLW;
              rx_st = RX_IDLE;
              r = with_fc(r, FS_OVERFLOW, 8'd0, 8'd0);
              r.status = STS_OVERFLOW;
            end else begin
              for (int i = 0; i < 6; i++) msg_mem[i] = b[2 + i];
              total_len = 12'(n);
              wr_off = 12'd6;
              exp_sn = 4'd1;
              rx_st = RX_BUSY;
              blk_left = cfg.bs_frames;
              r = with_fc(r, FS_CONTINUE, cfg.bs_frames, cfg.st_min_raw);
              tmo_left = cfg.timeout_ticks;
            end
          end else if (kind == PCI_CONSECUTIVE) begin
            if (rx_st != RX_BUSY) begin
              link_res = LR_UNEXP;
              r.status = STS_IGNORED;
            end else if ((b[0] & 8'(NIBBLE_MASK)) != 8'(exp_sn)) begin
              link_res = LR_WRONG_SN;
              rx_st = RX_IDLE;
              r.status = STS_WRONG_SN;
            end else begin
              n = (total_len > wr_off) ? total_len - wr_off : 0;
              if (n > 7) n = 7;
              if (n > len - 1) begin
                r.status = STS_LENGTH;
              end else begin
                for (int i = 0; i < n; i++) msg_mem[wr_off + i] = b[1 + i];
                wr_off = wr_off + 12'(n);
                exp_sn = exp_sn + 4'd1;
                tmo_left = cfg.timeout_ticks;
                if (wr_off >= total_len) begin
                  rx_st = RX_FULL;
                end else if (blk_left != 0) begin
                  blk_left = blk_left - 8'd1;
                  if (blk_left == 0) begin
                    blk_left = cfg.bs_frames;
                    r = with_fc(r, FS_CONTINUE, cfg.bs_frames, cfg.st_min_raw);
                  end
                end
              end
            end
          end else begin
            r.status = STS_IGNORED;
          end
        end
      end
      OP_TICK: begin
        if (rx_st == RX_BUSY) begin
          if (tmo_left == 0) begin
            link_res = LR_TIMEOUT;
            rx_st = RX_IDLE;
          end else begin
            tmo_left = tmo_left - 16'd1;
          end
        end
      end
      OP_READ: begin
        if (rx_st != RX_FULL) r.status = STS_NO_DATA;
        else if (it.read_index >= total_len) r.status = STS_LENGTH;
        else r.read_byte = msg_mem[it.read_index];
      end
      default: begin
        if (rx_st != RX_FULL) r.status = STS_NO_DATA;
        else rx_st = RX_IDLE;
      end
    endcase
    r.rx_state = rx_st;
    r.link_result = link_res;
    r.message_length = total_len;
    return r;
  endfunction

  function int unsigned pick_gap();
    if (no_stall) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("reply %0d %s: got %0h, expected %0h", reply_no, name, got, want));
    end
  endtask

  task automatic check_reply(logic [79:0] d);
    result_t want;
    if (reply_q.size() == 0) begin
      report_error($sformatf("reply %h arrived with no request outstanding", d));
      return;
    end
    want = reply_q.pop_front();
    compare_field("status", d[2:0], want.status);
    compare_field("rx_state", d[4:3], want.rx_state);
    compare_field("link_result", d[7:5], want.link_result);
    compare_field("fc_send", d[8], want.fc_send);
    compare_field("fc_flow_status", d[10:9], want.fc_flow_status);
    compare_field("fc_block_size", d[18:11], want.fc_block_size);
    compare_field("fc_st_min", d[25:19], want.fc_st_min);
    compare_field("fc_can_id", d[54:26], want.fc_can_id);
    compare_field("message_length", d[66:55], want.message_length);
    compare_field("read_byte", d[74:67], want.read_byte);
    compare_field("padding", d[79:75], '0);
    reply_no++;
  endtask

  // Request driver: each accepted request is predicted at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        reply_q.push_back(reassemble(cur_req));
        src_wait = pick_gap();
      end else begin
        src_wait = src_gap;
      end
      if (src_wait == 0 && req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cur_req.read_index, cur_req.frame_data, cur_req.frame_length};
        s_axis_tuser <= cur_req.op;
        src_gap <= 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        src_gap <= (src_wait == 0) ? 0 : src_wait - 1;
      end
    end
  end

  // Reply monitor: stalls for a drawn number of cycles after each reply.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply(m_axis_tdata);
        sink_wait = pick_gap();
      end else begin
        sink_wait = sink_gap;
      end
      if (sink_wait == 0) begin
        m_axis_tready <= 1'b1;
        sink_gap <= 0;
      end else begin
        m_axis_tready <= 1'b0;
        sink_gap <= sink_wait - 1;
      end
    end
  end

  task automatic push_req(op_e op, int unsigned len, logic [63:0] data, logic [11:0] idx,
                          bit tally);
    item_t it;
    it.op = op;
    it.frame_length = 4'(len);
    it.frame_data = data;
    it.read_index = idx;
    req_q.push_back(it);
    if (tally) counted++;
  endtask

  task automatic push_frame(int unsigned len, logic [63:0] data);
    push_req(OP_FRAME, len, data, 12'($urandom), 1'b1);
  endtask

  task automatic push_cmd(op_e op, logic [11:0] idx);
    push_req(op, $urandom_range(0, 15), {$urandom, $urandom}, idx, 1'b1);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [28:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BS_FRAMES:     cfg.bs_frames = val[7:0];
      CFG_ST_MIN:        cfg.st_min_raw = val[7:0];
      CFG_TIMEOUT_TICKS: cfg.timeout_ticks = val[15:0];
      default:           cfg.tx_id = val;
    endcase
  endtask

  task automatic set_regs(int unsigned bs, int unsigned st, int unsigned tmo, logic [28:0] id);
    write_reg(CFG_BS_FRAMES, 29'(bs));
    write_reg(CFG_ST_MIN, 29'(st));
    write_reg(CFG_TIMEOUT_TICKS, 29'(tmo));
    write_reg(CFG_TX_ID, id);
  endtask

  // Waits until every request has been answered, then lets the pipeline settle.
  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic read_out(int unsigned total);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) push_cmd(OP_READ, 12'($urandom_range(total, 4095)));
      else push_cmd(OP_READ, 12'($urandom_range(0, total - 1)));
    end
    if ($urandom_range(0, 4) != 0) push_cmd(OP_RELEASE, 12'($urandom));
  endtask

  task automatic push_noise();
    push_req(op_e'($urandom_range(0, 3)), $urandom_range(0, 15), {$urandom, $urandom},
             12'($urandom), 1'b0);
  endtask

  task automatic send_single();
    int unsigned n;
    logic [63:0] d;
    n = $urandom_range(1, 7);
    d = {$urandom, $urandom};
    d[63:56] = {PCI_SINGLE, 4'(n)};
    push_frame($urandom_range(n + 1, 8), d);
    read_out(n);
  endtask

  // A first frame and its consecutive frames, with ticks and the odd broken frame mixed in.
  task automatic send_multi();
    int unsigned total;
    int unsigned off;
    int unsigned n;
    int unsigned len;
    logic [3:0]  sn;
    logic [63:0] d;
    total = ($urandom_range(0, 11) == 0) ? $urandom_range(49, 300) : $urandom_range(8, 48);
    d = {$urandom, $urandom};
    d[63:48] = {PCI_FIRST, 12'(total)};
    push_frame(8, d);
    off = 6;
    sn = 4'd1;
    while (off < total) begin
      n = total - off;
      if (n > 7) n = 7;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) push_cmd(OP_TICK, 12'($urandom));
      d = {$urandom, $urandom};
      case ($urandom_range(0, 59))
        0: begin
          if (cfg.timeout_ticks <= 16) begin
            repeat (cfg.timeout_ticks + 1) push_cmd(OP_TICK, 12'($urandom));
            d[63:56] = {PCI_CONSECUTIVE, sn};
            push_frame(8, d);
            return;
          end
        end
        1: begin
          d[63:56] = {PCI_CONSECUTIVE, sn + 4'($urandom_range(1, 15))};
          push_frame(8, d);
          return;
        end
        2: begin
          // Frame too short for the bytes still owed; the message stays open.
          if (n > 1) begin
            d[63:56] = {PCI_CONSECUTIVE, sn};
            push_frame($urandom_range(2, n), d);
          end
        end
        3: push_noise();
        4: begin
          send_single();
          return;
        end
        default: ;
      endcase
      d = {$urandom, $urandom};
      d[63:56] = {PCI_CONSECUTIVE, sn};
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(n + 1, 8) : n + 1;
      push_frame(len, d);
      off += n;
      sn = sn + 4'd1;
    end
    read_out(total);
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned start;
    start = counted;
    while (counted - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_single();
        3, 4, 5, 6, 7: send_multi();
        default: repeat ($urandom_range(1, 3)) push_noise();
      endcase
    end
  endtask

  // Registers here: block size 2, separation time 200 (clamped), timeout 2, widest identifier.
  task automatic directed();
    push_cmd(OP_READ, 12'd0);
    push_cmd(OP_RELEASE, 12'd0);
    push_cmd(OP_TICK, 12'hFFF);
    push_frame(0, '1);
    push_frame(1, 64'h0211_0000_0000_0000);
    push_frame(15, 64'h0711_2233_4455_6677);
    push_frame(8, 64'h00AA_BBCC_DDEE_FF00);
    push_frame(3, 64'h0511_2233_4455_6677);
    push_frame(8, 64'h2111_2233_4455_6677);
    push_frame(3, 64'h3000_0000_0000_0000);
    push_frame(8, 64'hF123_4567_89AB_CDEF);
    push_frame(8, 64'h07FF_FFFF_FFFF_FFFF);
    push_cmd(OP_READ, 12'd6);
    push_cmd(OP_READ, 12'd7);
    push_frame(7, 64'h1014_0102_0304_0506);
    push_frame(8, 64'h1007_0102_0304_0506);
    push_frame(8, 64'h1FFF_0102_0304_0506);
    // A single frame in the middle of a message replaces it.
    push_frame(2, 64'h0155_FFFF_FFFF_FFFF);
    push_frame(8, 64'h1014_A1A2_A3A4_A5A6);
    push_frame(8, 64'h2200_0000_0000_0000);
    push_frame(8, 64'h1008_0000_0000_0000);
    repeat (3) push_cmd(OP_TICK, 12'd0);
    push_frame(8, 64'h1008_B1B2_B3B4_B5B6);
    push_frame(2, 64'h21C1_C2C3_C4C5_C6C7);
    push_frame(3, 64'h21C1_C2FF_FFFF_FFFF);
    push_cmd(OP_READ, 12'd7);
    push_cmd(OP_RELEASE, 12'd0);
  endtask

  initial begin
    cfg.bs_frames = 8'd8;
    cfg.st_min_raw = 8'd0;
    cfg.timeout_ticks = 16'd100;
    cfg.tx_id = '0;
    rx_st = RX_IDLE;
    link_res = LR_OK;
    exp_sn = '0;
    total_len = '0;
    wr_off = '0;
    blk_left = '0;
    tmo_left = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_regs(2, 200, 2, 29'h1FFF_FFFF);
    @(negedge clk_i);
    directed();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(0, 0, 1, '0);
        1: set_regs(255, 255, 65535, 29'h1FFF_FFFF);
        2: set_regs(1, 127, 3, 29'($urandom));
        3: set_regs($urandom_range(2, 6), 128, $urandom_range(2, 10), 29'($urandom));
        default: set_regs($urandom_range(0, 8), $urandom_range(0, 255), $urandom_range(1, 12),
                          29'($urandom));
      endcase
      no_stall = (ph == 2);
      @(negedge clk_i);
      random_phase(80);
      drain();
    end
    if (err_count == 0) begin
      $display("** isotp_receive_reassembler_unit: PASSED **");
    end else begin
      $display("** isotp_receive_reassembler_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("** isotp_receive_reassembler_unit: FAILED **");
    $finish;
  end

endmodule
